// ===== rtl/core/i2c_master_memory_transfer_defines.svh =====
// Assertion macros for the I2C memory transfer engine
`ifndef I2C_MASTER_MEMORY_TRANSFER_DEFINES_SVH
`define I2C_MASTER_MEMORY_TRANSFER_DEFINES_SVH
// implication checked every clock outside reset
`define I2CM_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("i2cm check failed");
// next-cycle implication
`define I2CM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("i2cm check failed");
`endif

// ===== rtl/core/i2cm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and constants for the I2C memory transfer engine.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_WRITE = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;
  localparam logic [1:0] FUNC_DATA  = 2'd3;

  localparam logic [1:0] REG_DEV_ADDR  = 2'd0;
  localparam logic [1:0] REG_ADDR_SIZE = 2'd1;
  localparam logic [1:0] REG_TIMEOUT   = 2'd2;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] mem_address;
    logic [15:0] byte_count;
    logic [7:0]  write_byte;
    logic        sda_in;
  } item_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       need_data;
    logic [7:0] read_byte;
    logic       read_valid;
    logic       done_res;
    logic       status;
    logic       busy_res;
  } result_t;

  typedef struct packed {
    logic [6:0] device_address;
    logic [1:0] address_bytes;
    logic [7:0] ack_timeout;
  } cfg_t;

endpackage

// ===== rtl/core/i2cm_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cm_front
// Input queue: takes item beats and holds them for the bus engine.
// ----------------------------------------------------------------------------
module i2cm_front import i2cm_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  output logic  full,
  input  item_t in_item,
  output logic  q_valid,
  input  logic  q_take,
  output item_t q_item
);

  item_t          mem [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QAW:0]   count;
  logic           do_push;
  logic           do_pop;

  assign full    = count == (QAW+1)'(QDEPTH);
  assign q_valid = count != '0;
  assign q_item  = mem[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = q_take && q_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= in_item;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (QAW+1)'(do_push) - (QAW+1)'(do_pop);
    end
  end

endmodule

// ===== rtl/core/i2cm_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cm_engine
// Bus sequencer: one item per cycle to a result register; stalls if unpopped.
// ----------------------------------------------------------------------------
module i2cm_engine import i2cm_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    q_valid,
  output logic    q_take,
  input  item_t   q_item,
  output logic    res_valid,
  input  logic    res_take,
  output result_t res
);

  typedef enum logic [4:0] {
    PH_IDLE, PH_START_A, PH_START_B, PH_START_C, PH_START_D,
    PH_TX_SET, PH_TX_HIGH, PH_TX_LOW, PH_ACK_REL, PH_ACK_HIGH, PH_ACK_POLL,
    PH_RX_HIGH, PH_RX_LOW, PH_MACK_SDA, PH_MACK_HIGH, PH_MACK_LOW, PH_MACK_REL,
    PH_WAIT_DATA, PH_STOP_A, PH_STOP_B, PH_STOP_C
  } phase_t;

  typedef enum logic [1:0] {KIND_DEV_W, KIND_MEM, KIND_DEV_R, KIND_DATA} kind_t;

  phase_t      phase, phase_next;
  logic [2:0]  bit_index, bit_index_next;
  logic [7:0]  shift_byte, shift_byte_next;
  logic [15:0] bytes_left, bytes_left_next;
  logic [15:0] address_hold, address_hold_next;
  logic [1:0]  address_left, address_left_next;
  logic [7:0]  wait_ticks, wait_ticks_next;
  logic        is_read, is_read_next;
  logic        scl_level, scl_level_next;
  logic        sda_level, sda_level_next;
  kind_t       tx_kind, tx_kind_next;
  logic        failed, failed_next;
  logic        valid, done, stat;

  assign q_take = q_valid && (!res_valid || res_take);

  always_comb begin
    phase_next        = phase;
    bit_index_next    = bit_index;
    shift_byte_next   = shift_byte;
    bytes_left_next   = bytes_left;
    address_hold_next = address_hold;
    address_left_next = address_left;
    wait_ticks_next   = wait_ticks;
    is_read_next      = is_read;
    scl_level_next    = scl_level;
    sda_level_next    = sda_level;
    tx_kind_next      = tx_kind;
    failed_next       = failed;
    valid = 1'b0;
    done  = 1'b0;
    stat  = 1'b0;
    case (q_item.func)
      FUNC_WRITE, FUNC_READ: begin
        if (phase == PH_IDLE) begin
          address_hold_next = q_item.mem_address;
          bytes_left_next   = q_item.byte_count;
          address_left_next = (cfg.address_bytes == 2'd3) ? 2'd0 : cfg.address_bytes;
          is_read_next      = q_item.func == FUNC_READ;
          tx_kind_next      = KIND_DEV_W;
          failed_next       = 1'b0;
          bit_index_next    = '0;
          phase_next        = PH_START_A;
        end
      end
      FUNC_DATA: begin
        if (phase == PH_WAIT_DATA) begin
          bytes_left_next = bytes_left - 16'd1;
          shift_byte_next = q_item.write_byte;
          tx_kind_next    = KIND_DATA;
          bit_index_next  = '0;
          phase_next      = PH_TX_SET;
        end
      end
      default: begin
        case (phase)
          PH_START_A: begin sda_level_next = 1'b1; phase_next = PH_START_B; end
          PH_START_B: begin scl_level_next = 1'b1; phase_next = PH_START_C; end
          PH_START_C: begin sda_level_next = 1'b0; phase_next = PH_START_D; end
          PH_START_D: begin
            scl_level_next  = 1'b0;
            shift_byte_next = {cfg.device_address, tx_kind == KIND_DEV_R};
            bit_index_next  = '0;
            phase_next      = PH_TX_SET;
          end
          PH_TX_SET: begin
            sda_level_next  = shift_byte[7];
            shift_byte_next = {shift_byte[6:0], 1'b0};
            phase_next      = PH_TX_HIGH;
          end
          PH_TX_HIGH: begin scl_level_next = 1'b1; phase_next = PH_TX_LOW; end
          PH_TX_LOW: begin
            scl_level_next = 1'b0;
            bit_index_next = bit_index + 3'd1;
            phase_next     = (bit_index == 3'd7) ? PH_ACK_REL : PH_TX_SET;
          end
          PH_ACK_REL: begin sda_level_next = 1'b1; phase_next = PH_ACK_HIGH; end
          PH_ACK_HIGH: begin
            scl_level_next  = 1'b1;
            wait_ticks_next = '0;
            phase_next      = PH_ACK_POLL;
          end
          PH_ACK_POLL: begin
            if (!q_item.sda_in) begin
              scl_level_next = 1'b0;
              if (tx_kind == KIND_DATA) begin
                phase_next = (bytes_left != '0) ? PH_WAIT_DATA : PH_STOP_A;
              end else if (tx_kind == KIND_DEV_R) begin
                phase_next = (bytes_left != '0) ? PH_RX_HIGH : PH_STOP_A;
              end else if (address_left != '0) begin
                shift_byte_next   = address_left[1] ? address_hold[15:8]
                                                    : address_hold[7:0];
                address_left_next = address_left - 2'd1;
                tx_kind_next      = KIND_MEM;
                bit_index_next    = '0;
                phase_next        = PH_TX_SET;
              end else if (is_read) begin
                tx_kind_next = KIND_DEV_R;
                phase_next   = PH_START_A;
              end else begin
                phase_next = (bytes_left != '0) ? PH_WAIT_DATA : PH_STOP_A;
              end
            end else if (wait_ticks >= cfg.ack_timeout) begin
              scl_level_next = 1'b0;
              failed_next    = 1'b1;
              phase_next     = PH_STOP_A;
            end else begin
              wait_ticks_next = wait_ticks + 8'd1;
            end
          end
          PH_RX_HIGH: begin
            sda_level_next = 1'b1;
            scl_level_next = 1'b1;
            phase_next     = PH_RX_LOW;
          end
          PH_RX_LOW: begin
            shift_byte_next = {shift_byte[6:0], q_item.sda_in};
            scl_level_next  = 1'b0;
            bit_index_next  = bit_index + 3'd1;
            if (bit_index == 3'd7) begin
              bytes_left_next = bytes_left - 16'd1;
              valid           = 1'b1;
              phase_next      = PH_MACK_SDA;
            end else begin
              phase_next = PH_RX_HIGH;
            end
          end
          PH_MACK_SDA: begin
            sda_level_next = bytes_left == '0;
            phase_next     = PH_MACK_HIGH;
          end
          PH_MACK_HIGH: begin scl_level_next = 1'b1; phase_next = PH_MACK_LOW; end
          PH_MACK_LOW: begin
            scl_level_next = 1'b0;
            phase_next     = (bytes_left != '0) ? PH_MACK_REL : PH_STOP_A;
          end
          PH_MACK_REL: begin sda_level_next = 1'b1; phase_next = PH_RX_HIGH; end
          PH_STOP_A: begin sda_level_next = 1'b0; phase_next = PH_STOP_B; end
          PH_STOP_B: begin scl_level_next = 1'b1; phase_next = PH_STOP_C; end
          PH_STOP_C: begin
            sda_level_next = 1'b1;
            done           = 1'b1;
            stat           = failed;
            failed_next    = 1'b0;
            phase_next     = PH_IDLE;
          end
          default: ;
        endcase
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      bit_index    <= '0;
      shift_byte   <= '0;
      bytes_left   <= '0;
      address_hold <= '0;
      address_left <= '0;
      wait_ticks   <= '0;
      is_read      <= 1'b0;
      scl_level    <= 1'b1;
      sda_level    <= 1'b1;
      tx_kind      <= KIND_DEV_W;
      failed       <= 1'b0;
      res_valid    <= 1'b0;
    end else begin
      res_valid <= q_take || (res_valid && !res_take);
      if (q_take) begin
        phase        <= phase_next;
        bit_index    <= bit_index_next;
        shift_byte   <= shift_byte_next;
        bytes_left   <= bytes_left_next;
        address_hold <= address_hold_next;
        address_left <= address_left_next;
        wait_ticks   <= wait_ticks_next;
        is_read      <= is_read_next;
        scl_level    <= scl_level_next;
        sda_level    <= sda_level_next;
        tx_kind      <= tx_kind_next;
        failed       <= failed_next;
        res.scl_out    <= scl_level_next;
        res.sda_out    <= sda_level_next;
        res.need_data  <= phase_next == PH_WAIT_DATA;
        res.read_byte  <= valid ? shift_byte_next : 8'd0;
        res.read_valid <= valid;
        res.done_res   <= done;
        res.status     <= stat;
        res.busy_res   <= phase_next != PH_IDLE;
      end
    end
  end

endmodule

// ===== rtl/core/i2cm_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cm_cfg
// Configuration register file.
// ----------------------------------------------------------------------------
module i2cm_cfg import i2cm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  output cfg_t       cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.device_address <= 7'd0;
      cfg.address_bytes  <= 2'd1;
      cfg.ack_timeout    <= 8'd250;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_DEV_ADDR:  cfg.device_address <= cfg_data[6:0];
        REG_ADDR_SIZE: cfg.address_bytes  <= cfg_data[1:0];
        REG_TIMEOUT:   cfg.ack_timeout    <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/core/i2c_master_memory_transfer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_master_memory_transfer
// I2C master running one register write or read, one bus step per item.
// ----------------------------------------------------------------------------
// Every accepted item (tick, begin write, begin read, write byte) produces
// exactly one result beat. A four-entry input queue feeds the bus sequencer,
// which retires one item per clock into a single result register, so the
// sustained rate is one item per cycle while results are popped; with the
// queue empty, an accepted item is stored in a queue entry and then
// registered in the result register before its beat is on the ports.
module i2c_master_memory_transfer import i2cm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  func,
  input  logic [15:0] mem_address,
  input  logic [15:0] byte_count,
  input  logic [7:0]  write_byte,
  input  logic        sda_in,
  output logic        empty,
  input  logic        pop,
  output logic        scl_out,
  output logic        sda_out,
  output logic        need_data,
  output logic [7:0]  read_byte,
  output logic        read_valid,
  output logic        done_res,
  output logic        status,
  output logic        busy_res,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  item_t   in_item, q_item;
  result_t res;
  cfg_t    cfg;
  logic    q_valid, q_take, res_valid;

  assign in_item = '{func: func, mem_address: mem_address, byte_count: byte_count,
                     write_byte: write_byte, sda_in: sda_in};

  i2cm_cfg u_cfg (
    .clk(clk), .rst(rst), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .cfg(cfg)
  );

  i2cm_front u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .in_item(in_item),
    .q_valid(q_valid), .q_take(q_take), .q_item(q_item)
  );

  i2cm_engine u_engine (
    .clk(clk), .rst(rst), .cfg(cfg), .q_valid(q_valid), .q_take(q_take),
    .q_item(q_item), .res_valid(res_valid), .res_take(pop && res_valid), .res(res)
  );

  assign empty      = !res_valid;
  assign scl_out    = res.scl_out;
  assign sda_out    = res.sda_out;
  assign need_data  = res.need_data;
  assign read_byte  = res.read_byte;
  assign read_valid = res.read_valid;
  assign done_res   = res.done_res;
  assign status     = res.status;
  assign busy_res   = res.busy_res;

endmodule

// ===== rtl/core/i2cm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cm_checker
// Port-level checks on result beats of the I2C memory transfer engine.
// ----------------------------------------------------------------------------
`include "i2c_master_memory_transfer_defines.svh"
module i2cm_checker (
  input logic       clk,
  input logic       rst,
  input logic       empty,
  input logic       pop,
  input logic       read_valid,
  input logic [7:0] read_byte,
  input logic       done_res,
  input logic       status,
  input logic       busy_res,
  input logic       need_data,
  input logic       scl_out,
  input logic       sda_out
);

  `I2CM_ASSERT_IMP(a_done_idle, !empty && done_res, !busy_res && scl_out && sda_out)
  `I2CM_ASSERT_IMP(a_status_done, !empty && status, done_res)
  `I2CM_ASSERT_IMP(a_rx_zero, !empty && !read_valid, read_byte == 8'd0)
  `I2CM_ASSERT_IMP(a_need_busy, !empty && need_data, busy_res && !scl_out)
  `I2CM_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(busy_res))

endmodule

bind i2c_master_memory_transfer i2cm_checker u_checker (
  .clk(clk), .rst(rst), .empty(empty), .pop(pop), .read_valid(read_valid),
  .read_byte(read_byte), .done_res(done_res), .status(status),
  .busy_res(busy_res), .need_data(need_data), .scl_out(scl_out), .sda_out(sda_out)
);

// ===== tb/i2c_master_memory_transfer_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_master_memory_transfer_checker
// Watches the item, result and register channels of the I2C transfer engine.
// It keeps its own copy of the bus sequencer and registers, works out the
// result of every accepted item, and compares each popped result beat with
// the oldest outstanding prediction. Mismatches are counted for the top.
// ----------------------------------------------------------------------------
module i2c_master_memory_transfer_checker import i2cm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic        full,
  input  logic [1:0]  func,
  input  logic [15:0] mem_address,
  input  logic [15:0] byte_count,
  input  logic [7:0]  write_byte,
  input  logic        sda_in,
  input  logic        empty,
  input  logic        pop,
  input  logic        scl_out,
  input  logic        sda_out,
  input  logic        need_data,
  input  logic [7:0]  read_byte,
  input  logic        read_valid,
  input  logic        done_res,
  input  logic        status,
  input  logic        busy_res,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  output int          err_count,
  output int          pending,
  output int          beats_checked,
  output int          transfers_done,
  output int          nack_done
);

  typedef enum logic [4:0] {
    S_IDLE, S_START_A, S_START_B, S_START_C, S_START_D,
    S_TX_SET, S_TX_HIGH, S_TX_LOW, S_ACK_REL, S_ACK_HIGH, S_ACK_POLL,
    S_RX_HIGH, S_RX_LOW, S_MACK_SDA, S_MACK_HIGH, S_MACK_LOW, S_MACK_REL,
    S_WAIT_DATA, S_STOP_A, S_STOP_B, S_STOP_C
  } bus_state_e;

  typedef enum logic [1:0] {K_DEV_W, K_MEM, K_DEV_R, K_DATA} byte_kind_e;

  cfg_t       regs;
  bus_state_e st;
  logic [2:0] bit_n;
  logic [7:0] shreg;
  logic [15:0] remaining;
  logic [15:0] addr_hold;
  logic [1:0] addr_left;
  logic [7:0] polls;
  logic       rd_xfer;
  logic       scl_q, sda_q;
  byte_kind_e kind;
  logic       nack_seen;

  result_t expected_beats[$];

  task automatic load_byte(input logic [7:0] b, input byte_kind_e k);
    shreg = b;
    kind  = k;
    bit_n = 0;
    st    = S_TX_SET;
  endtask

  task automatic acked();
    if (kind == K_DATA) begin
      st = (remaining != 0) ? S_WAIT_DATA : S_STOP_A;
    end else if (kind == K_DEV_R) begin
      st = (remaining != 0) ? S_RX_HIGH : S_STOP_A;
    end else if (addr_left != 0) begin
      logic [7:0] b;
      b = (addr_left >= 2) ? addr_hold[15:8] : addr_hold[7:0];
      addr_left = addr_left - 1;
      load_byte(b, K_MEM);
    end else if (rd_xfer) begin
      kind = K_DEV_R;
      st   = S_START_A;
    end else begin
      st = (remaining != 0) ? S_WAIT_DATA : S_STOP_A;
    end
  endtask

  task automatic bus_step(input item_t it, output result_t r);
    logic got, fin, fail_stat;
    got = 0;
    fin = 0;
    fail_stat = 0;
    if (it.func == FUNC_WRITE || it.func == FUNC_READ) begin
      if (st == S_IDLE) begin
        addr_hold = it.mem_address;
        remaining = it.byte_count;
        addr_left = (regs.address_bytes == 2'd3) ? 2'd0 : regs.address_bytes;
        rd_xfer   = (it.func == FUNC_READ);
        kind      = K_DEV_W;
        nack_seen = 0;
        bit_n     = 0;
        st        = S_START_A;
      end
    end else if (it.func == FUNC_DATA) begin
      if (st == S_WAIT_DATA) begin
        remaining = remaining - 1;
        load_byte(it.write_byte, K_DATA);
      end
    end else begin
      case (st)
        S_START_A: begin sda_q = 1; st = S_START_B; end
        S_START_B: begin scl_q = 1; st = S_START_C; end
        S_START_C: begin sda_q = 0; st = S_START_D; end
        S_START_D: begin
          scl_q = 0;
          load_byte({regs.device_address, kind == K_DEV_R}, kind);
        end
        S_TX_SET: begin
          sda_q = shreg[7];
          shreg = shreg << 1;
          st = S_TX_HIGH;
        end
        S_TX_HIGH: begin scl_q = 1; st = S_TX_LOW; end
        S_TX_LOW: begin
          scl_q = 0;
          if (bit_n == 7) begin
            bit_n = 0;
            st = S_ACK_REL;
          end else begin
            bit_n = bit_n + 1;
            st = S_TX_SET;
          end
        end
        S_ACK_REL: begin sda_q = 1; st = S_ACK_HIGH; end
        S_ACK_HIGH: begin scl_q = 1; polls = 0; st = S_ACK_POLL; end
        S_ACK_POLL: begin
          if (!it.sda_in) begin
            scl_q = 0;
            acked();
          end else if (polls >= regs.ack_timeout) begin
            scl_q = 0;
            nack_seen = 1;
            st = S_STOP_A;
          end else begin
            polls = polls + 1;
          end
        end
        S_RX_HIGH: begin sda_q = 1; scl_q = 1; st = S_RX_LOW; end
        S_RX_LOW: begin
          shreg = {shreg[6:0], it.sda_in};
          scl_q = 0;
          if (bit_n == 7) begin
            bit_n = 0;
            remaining = remaining - 1;
            got = 1;
            st = S_MACK_SDA;
          end else begin
            bit_n = bit_n + 1;
            st = S_RX_HIGH;
          end
        end
        S_MACK_SDA: begin sda_q = (remaining == 0); st = S_MACK_HIGH; end
        S_MACK_HIGH: begin scl_q = 1; st = S_MACK_LOW; end
        S_MACK_LOW: begin
          scl_q = 0;
          st = (remaining != 0) ? S_MACK_REL : S_STOP_A;
        end
        S_MACK_REL: begin sda_q = 1; st = S_RX_HIGH; end
        S_STOP_A: begin sda_q = 0; st = S_STOP_B; end
        S_STOP_B: begin scl_q = 1; st = S_STOP_C; end
        S_STOP_C: begin
          sda_q = 1;
          fin = 1;
          fail_stat = nack_seen;
          nack_seen = 0;
          st = S_IDLE;
        end
        default: ;
      endcase
    end
    r.scl_out    = scl_q;
    r.sda_out    = sda_q;
    r.need_data  = (st == S_WAIT_DATA);
    r.read_byte  = got ? shreg : 8'h00;
    r.read_valid = got;
    r.done_res   = fin;
    r.status     = fail_stat;
    r.busy_res   = (st != S_IDLE);
  endtask

  task automatic cmp_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      err_count++;
    end
  endtask

  always @(posedge clk) begin
    item_t   it;
    result_t r;
    if (rst) begin
      regs      <= '{device_address: 7'd0, address_bytes: 2'd1, ack_timeout: 8'd250};
      st        = S_IDLE;
      bit_n     = 0;
      shreg     = 0;
      remaining = 0;
      addr_hold = 0;
      addr_left = 0;
      polls     = 0;
      rd_xfer   = 0;
      scl_q     = 1;
      sda_q     = 1;
      kind      = K_DEV_W;
      nack_seen = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_DEV_ADDR:  regs.device_address <= cfg_data[6:0];
          REG_ADDR_SIZE: regs.address_bytes  <= cfg_data[1:0];
          REG_TIMEOUT:   regs.ack_timeout    <= cfg_data;
          default: ;
        endcase
      end
      if (push && !full) begin
        it = '{func: func, mem_address: mem_address, byte_count: byte_count,
               write_byte: write_byte, sda_in: sda_in};
        bus_step(it, r);
        expected_beats.push_back(r);
      end
      if (pop && !empty) begin
        if (expected_beats.size() == 0) begin
          $error("result beat with no prediction outstanding");
          err_count++;
        end else begin
          r = expected_beats.pop_front();
          cmp_field("scl_out", r.scl_out, scl_out);
          cmp_field("sda_out", r.sda_out, sda_out);
          cmp_field("need_data", r.need_data, need_data);
          cmp_field("read_byte", r.read_byte, read_byte);
          cmp_field("read_valid", r.read_valid, read_valid);
          cmp_field("done_res", r.done_res, done_res);
          cmp_field("status", r.status, status);
          cmp_field("busy_res", r.busy_res, busy_res);
          beats_checked++;
          if (done_res) transfers_done++;
          if (done_res && status) nack_done++;
        end
      end
      pending <= expected_beats.size();
    end
  end

  initial begin
    err_count = 0;
    pending = 0;
    beats_checked = 0;
    transfers_done = 0;
    nack_done = 0;
  end

endmodule

// ===== tb/i2c_master_memory_transfer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_master_memory_transfer_tb
// Drives register writes and bus items into the I2C transfer engine across
// four register settings and three idling modes, with one long result stall.
// Prediction and comparison live in the checker; this top gives the verdict.
// ----------------------------------------------------------------------------
module i2c_master_memory_transfer_tb;
  import i2cm_pkg::*;

  logic        clk = 0;
  logic        rst = 1;
  logic        push = 0;
  logic        full;
  logic [1:0]  func = FUNC_TICK;
  logic [15:0] mem_address = 0;
  logic [15:0] byte_count = 0;
  logic [7:0]  write_byte = 0;
  logic        sda_in = 1;
  logic        empty;
  logic        pop = 0;
  logic        scl_out, sda_out, need_data, read_valid, done_res, status, busy_res;
  logic [7:0]  read_byte;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = REG_DEV_ADDR;
  logic [7:0]  cfg_data = 0;

  int err_count, pending, beats_checked, transfers_done, nack_done;
  int send_idle = 0;
  int recv_idle = 0;
  int items_sent = 0;
  bit hold_req = 0;
  int quiet_cycles = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  i2c_master_memory_transfer uut (.*);

  i2c_master_memory_transfer_checker chk (.*);

  always @(posedge clk) begin
    if (hold_req) begin
      pop <= 0;
      repeat (300) @(posedge clk);
      hold_req <= 0;
    end else begin
      pop <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready) || rst)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= 5000) begin
      $display("i2c_master_memory_transfer_tb: done, errors");
      $finish;
    end
  end

  task automatic send_beat(input item_t it);
    while ($urandom_range(99) < send_idle) begin
      push <= 0;
      @(posedge clk);
    end
    push        <= 1;
    func        <= it.func;
    mem_address <= it.mem_address;
    byte_count  <= it.byte_count;
    write_byte  <= it.write_byte;
    sda_in      <= it.sda_in;
    @(posedge clk);
    while (full) @(posedge clk);
    items_sent++;
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [7:0] val);
    push <= 0;
    @(posedge clk);
    while (pending != 0 || !empty) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
  endtask

  function automatic item_t random_beat();
    item_t it;
    int    roll;
    roll = $urandom_range(99);
    it.func = (roll < 6) ? FUNC_WRITE : (roll < 12) ? FUNC_READ :
              (roll < 24) ? FUNC_DATA : FUNC_TICK;
    it.mem_address = $urandom;
    it.byte_count = $urandom_range(0, 3);
    if (it.func == FUNC_WRITE && $urandom_range(99) < 8) it.byte_count = $urandom;
    it.write_byte = $urandom;
    it.sda_in = ($urandom_range(99) < 30);
    return it;
  endfunction

  task automatic run_random(input int n);
    repeat (n) send_beat(random_beat());
  endtask

  initial begin
    item_t it;
    repeat (9) @(posedge clk);
    rst <= 0;

    send_idle = 20;
    recv_idle = 45;
    reg_write(REG_DEV_ADDR, 8'h00);
    reg_write(REG_ADDR_SIZE, 8'd0);
    reg_write(REG_TIMEOUT, 8'd1);
    // stray data byte while idle, then a maximal write, a begin while busy
    it = '{func: FUNC_DATA, mem_address: 16'hFFFF, byte_count: 16'hFFFF,
           write_byte: 8'hFF, sda_in: 1'b1};
    send_beat(it);
    it.func = FUNC_WRITE;
    send_beat(it);
    it.func = FUNC_READ;
    it.mem_address = 16'h0000;
    send_beat(it);
    it.func = FUNC_TICK;
    repeat (22) send_beat(it);
    run_random(200);

    send_idle = 45;
    recv_idle = 20;
    reg_write(REG_DEV_ADDR, 8'h7F);
    reg_write(REG_ADDR_SIZE, 8'd2);
    reg_write(REG_TIMEOUT, 8'd255);
    run_random(200);

    send_idle = 0;
    recv_idle = 0;
    reg_write(REG_DEV_ADDR, 8'($urandom_range(0, 127)));
    reg_write(REG_ADDR_SIZE, 8'd3);
    reg_write(REG_TIMEOUT, 8'd0);
    hold_req <= 1;
    run_random(200);

    reg_write(REG_DEV_ADDR, 8'($urandom_range(0, 127)));
    reg_write(REG_ADDR_SIZE, 8'd1);
    reg_write(REG_TIMEOUT, 8'($urandom_range(1, 40)));
    run_random(200);

    push <= 0;
    @(posedge clk);
    while (pending != 0 || !empty) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("covered %0d items and %0d result beats over four register settings",
             items_sent, beats_checked);
    $display("transfers ended: %0d, of them on missing ack: %0d", transfers_done,
             nack_done);
    if (err_count == 0)
      $display("i2c_master_memory_transfer_tb: done, clean");
    else
      $display("i2c_master_memory_transfer_tb: done, errors");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/i2cm_pkg.sv
rtl/core/i2cm_front.sv
rtl/core/i2cm_engine.sv
rtl/core/i2cm_cfg.sv
rtl/core/i2c_master_memory_transfer.sv
rtl/core/i2cm_checker.sv
tb/i2c_master_memory_transfer_checker.sv
tb/i2c_master_memory_transfer_tb.sv
